/* src/ordered_dither_palette_mapper_assert.svh */
// Assertion macros used by the port-level checker of the palette mapper.
`ifndef ORDERED_DITHER_PALETTE_MAPPER_ASSERT_SVH
`define ORDERED_DITHER_PALETTE_MAPPER_ASSERT_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ODPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion that also holds while reset is asserted.
`define ODPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/odpm_pkg.sv */
// Package with widths, mode codes and arithmetic constants of the palette mapper.
`default_nettype none

package odpm_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned IndexW = 8;

  typedef enum logic [1:0] {
    MODE_CUBE = 2'd0,
    MODE_GREY = 2'd1,
    MODE_MONO = 2'd2
  } pixel_mode_e;

  localparam pixel_mode_e ModeReset = MODE_GREY;

  // Color cube.
  localparam int unsigned LevelStep = 51;
  localparam int unsigned CubeR     = 36;
  localparam int unsigned CubeG     = 6;

  // Luminance weights in thousandths; the grey index is floor(sum / 1000) / 2.
  localparam int unsigned LumWR     = 299;
  localparam int unsigned LumWG     = 587;
  localparam int unsigned LumWB     = 114;
  localparam int unsigned LumDiv    = 1000;
  localparam int unsigned LumSumW   = 18;
  localparam int unsigned LumShift  = 28;
  localparam int unsigned LumRecip  = (1 << LumShift) / LumDiv;
  localparam int unsigned LumRecipW = 19;

  // Mono level: (32r + 64g + 16b) * 64 / 28560 = (2r + 4g + b) * 64 / 1785.
  localparam int unsigned MonoSumW   = 11;
  localparam int unsigned MonoNumW   = 17;
  localparam int unsigned MonoDiv    = 28560 / 16;
  localparam int unsigned MonoShift  = 24;
  localparam int unsigned MonoRecip  = (1 << MonoShift) / MonoDiv;
  localparam int unsigned MonoRecipW = 14;
  localparam int unsigned MonoLevelW = 7;
  localparam int unsigned MonoOrder  = 3;

endpackage

`default_nettype wire

/* src/odpm_if.sv */
// Stream interfaces for pixel words in and index words out.
`default_nettype none

interface odpm_pix_in_if import odpm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;
  logic [ChanW-1:0]  red;
  logic [ChanW-1:0]  green;
  logic [ChanW-1:0]  blue;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red, green, blue, output ready);
endinterface

interface odpm_idx_out_if import odpm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] color_index;
  logic              mono_bit;

  modport source (output valid, color_index, mono_bit, input ready);
  modport sink   (input valid, color_index, mono_bit, output ready);
endinterface

`default_nettype wire

/* src/ordered_dither_palette_mapper.sv */
// Ordered-dither palette mapper: RGB pixel and position in, display index out.
//
// Use: pixel words enter on pix_in (valid/ready) and carry the column, the row
// and the three channel bytes. Index words leave on pix_out (valid/ready) and
// carry color_index and mono_bit. The pixel mode is set by pulsing
// pixel_mode_we_i with pixel_mode_i; write it only while no word is in flight.
// Mode 0 dithers each channel to six levels against a Bayer threshold, mode 1
// gives a 128-level grey index and modes 2 and 3 give a 65-level grey level
// plus the matching bit of an 8x8 Bayer tile.
//
// The datapath is a three-stage pipeline: channel sums, cube levels and the
// thresholds in the first stage, the reciprocal multiplications in the
// second, and the remainder correction with the mode select in the third,
// which is also the output register. A word accepted on pix_in loads the
// first stage, then the second, then the third, which drives pix_out.
// One word is taken every cycle while pix_out.ready stays high; the rate
// is set by one pass through each stage, and no state links one pixel to
// the next. When the receiver stalls, each stage holds its word and only
// empty stages fill, so pix_in.ready drops once all three stages are full.
// Reset empties the pipeline and sets the mode to greyscale.
`default_nettype none

module ordered_dither_palette_mapper import odpm_pkg::*; #(
  parameter int unsigned MATRIX_ORDER_LOG2 = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pixel_mode_we_i,
  input  wire logic [1:0] pixel_mode_i,
  odpm_pix_in_if.sink     pix_in,
  odpm_idx_out_if.source  pix_out
);

  localparam int unsigned ThrW   = 2 * MATRIX_ORDER_LOG2;
  localparam int unsigned ThrMW  = 2 * MonoOrder;
  localparam int unsigned CmpW   = (ThrW > 6) ? ThrW : 6;
  localparam int unsigned LumPW  = LumSumW + LumRecipW;
  localparam int unsigned MonoPW = MonoNumW + MonoRecipW;

  // Bit-interleaved Bayer threshold: bit k of the position lands in the
  // highest pair for k = 0, so low position bits weigh most.
  function automatic logic [ThrW-1:0] cube_thr(input logic [CoordW-1:0] x,
                                               input logic [CoordW-1:0] y);
    logic [ThrW-1:0] d;
    d = '0;
    for (int k = 0; k < MATRIX_ORDER_LOG2; k++) begin
      d[2*(MATRIX_ORDER_LOG2-1-k)+1] = x[k] ^ y[k];
      d[2*(MATRIX_ORDER_LOG2-1-k)]   = y[k];
    end
    return d;
  endfunction

  function automatic logic [ThrMW-1:0] mono_thr(input logic [CoordW-1:0] x,
                                                input logic [CoordW-1:0] y);
    logic [ThrMW-1:0] d;
    d = '0;
    for (int k = 0; k < MonoOrder; k++) begin
      d[2*(MonoOrder-1-k)+1] = x[k] ^ y[k];
      d[2*(MonoOrder-1-k)]   = y[k];
    end
    return d;
  endfunction

  // Six-level quantizer. For a full-scale byte the remainder is zero, so the
  // level is five whatever the threshold.
  function automatic logic [2:0] cube_level(input logic [ChanW-1:0] v,
                                            input logic [ThrW-1:0]  t);
    logic [2:0]       q;
    logic [ChanW-1:0] r;
    q = 3'(v >= ChanW'(LevelStep))     + 3'(v >= ChanW'(2 * LevelStep)) +
        3'(v >= ChanW'(3 * LevelStep)) + 3'(v >= ChanW'(4 * LevelStep)) +
        3'(v >= ChanW'(5 * LevelStep));
    r = v - ChanW'(q) * ChanW'(LevelStep);
    return (CmpW'(r[5:0]) > CmpW'(t)) ? q + 3'd1 : q;
  endfunction

  // Mode register.
  pixel_mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (pixel_mode_we_i) begin
      mode_q <= pixel_mode_e'(pixel_mode_i);
    end
  end

  // Handshake: a stage loads when it is empty or its word moves on.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_en, s2_en, s3_en;

  assign s3_en        = !s3_valid_q || pix_out.ready;
  assign s2_en        = !s2_valid_q || s3_en;
  assign s1_en        = !s1_valid_q || s2_en;
  assign pix_in.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= pix_in.valid;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Stage 1: channel sums, cube levels and thresholds.
  logic [LumSumW-1:0]  lum_sum_d, lum_sum_s1_q;
  logic [MonoSumW-1:0] mono_sum_d, mono_sum_s1_q;
  logic [2:0]          lvl_r_d, lvl_g_d, lvl_b_d;
  logic [2:0]          lvl_r_s1_q, lvl_g_s1_q, lvl_b_s1_q;
  logic [ThrMW-1:0]    thr_m_d, thr_m_s1_q;
  logic [ThrW-1:0]     thr_c;
  pixel_mode_e         mode_s1_q;

  always_comb begin
    thr_c      = cube_thr(pix_in.pixel_x, pix_in.pixel_y);
    thr_m_d    = mono_thr(pix_in.pixel_x, pix_in.pixel_y);
    lvl_r_d    = cube_level(pix_in.red, thr_c);
    lvl_g_d    = cube_level(pix_in.green, thr_c);
    lvl_b_d    = cube_level(pix_in.blue, thr_c);
    lum_sum_d  = LumSumW'(pix_in.red)   * LumSumW'(LumWR) +
                 LumSumW'(pix_in.green) * LumSumW'(LumWG) +
                 LumSumW'(pix_in.blue)  * LumSumW'(LumWB);
    mono_sum_d = MonoSumW'({pix_in.red, 1'b0}) +
                 MonoSumW'({pix_in.green, 2'b00}) +
                 MonoSumW'(pix_in.blue);
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      lum_sum_s1_q  <= lum_sum_d;
      mono_sum_s1_q <= mono_sum_d;
      lvl_r_s1_q    <= lvl_r_d;
      lvl_g_s1_q    <= lvl_g_d;
      lvl_b_s1_q    <= lvl_b_d;
      thr_m_s1_q    <= thr_m_d;
      mode_s1_q     <= mode_q;
    end
  end

  // Stage 2: reciprocal multiplications and the cube index.
  logic [LumPW-1:0]      lum_prod;
  logic [MonoPW-1:0]     mono_prod;
  logic [MonoNumW-1:0]   mono_num_s1;
  logic [IndexW-1:0]     lum_est_d, lum_est_s2_q;
  logic [MonoLevelW-1:0] mono_est_d, mono_est_s2_q;
  logic [IndexW-1:0]     cube_idx_d, cube_idx_s2_q;
  logic [LumSumW-1:0]    lum_sum_s2_q;
  logic [MonoNumW-1:0]   mono_num_s2_q;
  logic [ThrMW-1:0]      thr_m_s2_q;
  pixel_mode_e           mode_s2_q;

  always_comb begin
    mono_num_s1 = {mono_sum_s1_q, 6'b000000};
    lum_prod    = LumPW'(lum_sum_s1_q) * LumPW'(LumRecip);
    mono_prod   = MonoPW'(mono_num_s1) * MonoPW'(MonoRecip);
    lum_est_d   = lum_prod[LumShift +: IndexW];
    mono_est_d  = mono_prod[MonoShift +: MonoLevelW];
    cube_idx_d  = IndexW'(lvl_r_s1_q) * IndexW'(CubeR) +
                  IndexW'(lvl_g_s1_q) * IndexW'(CubeG) + IndexW'(lvl_b_s1_q);
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      lum_est_s2_q  <= lum_est_d;
      mono_est_s2_q <= mono_est_d;
      cube_idx_s2_q <= cube_idx_d;
      lum_sum_s2_q  <= lum_sum_s1_q;
      mono_num_s2_q <= mono_num_s1;
      thr_m_s2_q    <= thr_m_s1_q;
      mode_s2_q     <= mode_s1_q;
    end
  end

  // Stage 3: the estimates are exact or one low; one compare fixes them.
  logic [LumSumW-1:0]    lum_rem;
  logic [MonoNumW-1:0]   mono_rem;
  logic [IndexW-1:0]     lum_q;
  logic [MonoLevelW-1:0] mono_lvl;
  logic [IndexW-1:0]     idx_d, idx_q;
  logic                  bit_d, bit_q;

  always_comb begin
    lum_rem  = lum_sum_s2_q - LumSumW'(lum_est_s2_q) * LumSumW'(LumDiv);
    mono_rem = mono_num_s2_q - MonoNumW'(mono_est_s2_q) * MonoNumW'(MonoDiv);
    lum_q    = lum_est_s2_q + IndexW'(lum_rem >= LumSumW'(LumDiv));
    mono_lvl = mono_est_s2_q + MonoLevelW'(mono_rem >= MonoNumW'(MonoDiv));
    bit_d    = 1'b0;
    unique case (mode_s2_q)
      MODE_CUBE: idx_d = cube_idx_s2_q;
      MODE_GREY: idx_d = {1'b0, lum_q[IndexW-1:1]};
      default: begin
        // Mode 3 decodes as mono.
        idx_d = IndexW'(mono_lvl);
        bit_d = mono_lvl <= MonoLevelW'(thr_m_s2_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      idx_q <= idx_d;
      bit_q <= bit_d;
    end
  end

  assign pix_out.valid       = s3_valid_q;
  assign pix_out.color_index = idx_q;
  assign pix_out.mono_bit    = bit_q;

endmodule

`default_nettype wire

/* src/odpm_checker.sv */
// Port-level checker for the palette mapper, bound to the top level.
`default_nettype none

`include "ordered_dither_palette_mapper_assert.svh"

module odpm_checker import odpm_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [IndexW-1:0] color_index_i,
  input wire logic              mono_bit_i
);

  // An edge that sees reset leaves the output side empty.
  `ODPM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_i, "output valid after reset")

  // A stalled word keeps its valid and its payload.
  `ODPM_ASSERT(a_stall_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(color_index_i) && $stable(mono_bit_i), "stalled output word changed")

  // No mode gives an index beyond the color cube.
  `ODPM_ASSERT(a_index_range, out_valid_i |-> color_index_i <= 8'd215, "color index beyond 215")

  // The tile bit only comes with a mono level, which never exceeds 64.
  `ODPM_ASSERT(a_mono_range, out_valid_i && mono_bit_i |-> color_index_i <= 8'd64, "mono bit with index beyond 64")

endmodule

bind ordered_dither_palette_mapper odpm_checker u_odpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (pix_out.valid),
  .out_ready_i   (pix_out.ready),
  .color_index_i (pix_out.color_index),
  .mono_bit_i    (pix_out.mono_bit)
);

`default_nettype wire
